FILE: src/sti_pkg.sv
package sti_pkg;

   localparam int COORD_BITS = 16;
   localparam int T_BITS     = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int NORM_BITS  = 2 * DIFF_BITS + 1;
   localparam int DOT_BITS   = NORM_BITS + DIFF_BITS + 2;
   localparam int M_BITS     = NORM_BITS + DIFF_BITS + 1;
   localparam int REM_BITS   = DOT_BITS + 2;
   localparam int PT_BITS    = COORD_BITS + 2;
   localparam int DV_BITS    = PT_BITS + 1;
   localparam int ML_BITS    = 27;
   localparam int MH_BITS    = M_BITS - ML_BITS;
   localparam int PL_BITS    = DV_BITS + ML_BITS + 1;
   localparam int PH_BITS    = DV_BITS + MH_BITS;
   localparam int SL_BITS    = PL_BITS + 2;
   localparam int SH_BITS    = PH_BITS + 2;
   localparam int TOT_BITS   = SH_BITS + ML_BITS + 2;
   localparam int DIV_STAGES = T_BITS;

   typedef struct packed {
      logic [47:0] vertex_a;
      logic [47:0] vertex_b;
      logic [47:0] vertex_c;
      logic [47:0] seg_start;
      logic [47:0] seg_end;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic signed [15:0] point_z;
   } rsp_type;

   // Vertices, segment start and direction carried down the pipeline.
   typedef struct packed {
      logic [2:0][COORD_BITS-1:0] a;
      logic [2:0][COORD_BITS-1:0] b;
      logic [2:0][COORD_BITS-1:0] c;
      logic [2:0][COORD_BITS-1:0] s;
      logic [2:0][DIFF_BITS-1:0]  dir;
   } geo_type;

   typedef struct packed {
      logic [REM_BITS-1:0]         r;
      logic [REM_BITS-1:0]         d;
      logic [T_BITS-1:0]           q;
      logic                        eq;
      logic                        miss;
      logic [2:0][2:0][M_BITS-1:0] m;
      geo_type                     geo;
   } div_type;

endpackage

FILE: src/segment_triangle_intersect.sv
// Throughput: one word per cycle when not stalled; a 16-stage restoring divider,
// one quotient bit per stage, sets the depth, and every stage advances together.
// A stalled rsp word holds the whole pipeline, so nothing is lost or repeated.
// Reset (synchronous, active high) clears every valid bit; the data path
// registers are not reset.
module segment_triangle_intersect (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  sti_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output sti_pkg::rsp_type rsp_data
);

   localparam int CB = sti_pkg::COORD_BITS;
   localparam int DB = sti_pkg::DIFF_BITS;
   localparam int NB = sti_pkg::NORM_BITS;
   localparam int PB = sti_pkg::NORM_BITS + sti_pkg::DIFF_BITS;
   localparam int SB = sti_pkg::DOT_BITS;
   localparam int MB = sti_pkg::M_BITS;
   localparam int RB = sti_pkg::REM_BITS;
   localparam int TB = sti_pkg::T_BITS;
   localparam int XB = 2 * DB;
   localparam int QP = DB + TB + 2;
   localparam int TP = sti_pkg::PT_BITS;
   localparam int VB = sti_pkg::DV_BITS;
   localparam int LB = sti_pkg::ML_BITS;
   localparam int NS = sti_pkg::DIV_STAGES;

   logic rsp_valid_ff;
   logic en;
   assign en = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // ---------------- stage 1: unpack and differences
   logic                        v1_ff;
   sti_pkg::geo_type            g1_ff, g1_in;
   logic signed [DB-1:0]        e1_ff [3], e2_ff [3], ca_ff [3], sa_ff [3];
   logic signed [DB-1:0]        e1_in [3], e2_in [3], ca_in [3], sa_in [3];

   always_comb begin
      logic signed [CB-1:0] pa, pb, pc, ps, pe;
      for (int k = 0; k < 3; k++) begin
         pa = req_data.vertex_a[k*CB +: CB];
         pb = req_data.vertex_b[k*CB +: CB];
         pc = req_data.vertex_c[k*CB +: CB];
         ps = req_data.seg_start[k*CB +: CB];
         pe = req_data.seg_end[k*CB +: CB];
         g1_in.a[k]   = pa;
         g1_in.b[k]   = pb;
         g1_in.c[k]   = pc;
         g1_in.s[k]   = ps;
         g1_in.dir[k] = DB'(pe - ps);
         e1_in[k] = DB'(pb - pa);
         e2_in[k] = DB'(pc - pb);
         ca_in[k] = DB'(pa - pc);
         sa_in[k] = DB'(ps - pa);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
      if (en) begin
         g1_ff <= g1_in;
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         ca_ff <= ca_in;
         sa_ff <= sa_in;
      end
   end

   // ---------------- stage 2: normal partial products
   logic                 v2_ff;
   sti_pkg::geo_type     g2_ff;
   logic signed [XB-1:0] na_ff [3], nb_ff [3];
   logic signed [DB-1:0] e1b_ff [3], e2b_ff [3], cab_ff [3], sab_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            na_ff[k] <= e1_ff[(k+1)%3] * e2_ff[(k+2)%3];
            nb_ff[k] <= e1_ff[(k+2)%3] * e2_ff[(k+1)%3];
         end
         g2_ff  <= g1_ff;
         e1b_ff <= e1_ff;
         e2b_ff <= e2_ff;
         cab_ff <= ca_ff;
         sab_ff <= sa_ff;
      end
   end

   // ---------------- stage 3: normal
   logic                 v3_ff;
   sti_pkg::geo_type     g3_ff;
   logic signed [NB-1:0] n_ff [3];
   logic signed [DB-1:0] e1c_ff [3], e2c_ff [3], cac_ff [3], sac_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            n_ff[k] <= NB'(na_ff[k]) - NB'(nb_ff[k]);
         end
         g3_ff  <= g2_ff;
         e1c_ff <= e1b_ff;
         e2c_ff <= e2b_ff;
         cac_ff <= cab_ff;
         sac_ff <= sab_ff;
      end
   end

   // ---------------- stage 4: dot and edge cross products
   // Each edge test (e x d).n is rewritten as d.(n x e), so n x e is built
   // here, ahead of the point.
   logic                 v4_ff;
   sti_pkg::geo_type     g4_ff;
   logic signed [PB-1:0] dp_ff [3], sp_ff [3];
   logic signed [PB-1:0] ma_ff [3][3], mb_ff [3][3];
   logic signed [DB-1:0] edg [3][3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         edg[0][k] = e1c_ff[k];
         edg[1][k] = e2c_ff[k];
         edg[2][k] = cac_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            dp_ff[k] <= n_ff[k] * $signed(g3_ff.dir[k]);
            sp_ff[k] <= n_ff[k] * sac_ff[k];
            for (int j = 0; j < 3; j++) begin
               ma_ff[j][k] <= n_ff[(k+1)%3] * edg[j][(k+2)%3];
               mb_ff[j][k] <= n_ff[(k+2)%3] * edg[j][(k+1)%3];
            end
         end
         g4_ff <= g3_ff;
      end
   end

   // ---------------- stage 5: sums
   logic                        v5_ff;
   sti_pkg::geo_type            g5_ff;
   logic signed [SB-1:0]        den_ff, num_ff;
   logic [2:0][2:0][MB-1:0]     m5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
      if (en) begin
         den_ff <= SB'(dp_ff[0]) + SB'(dp_ff[1]) + SB'(dp_ff[2]);
         num_ff <= SB'(sp_ff[0]) + SB'(sp_ff[1]) + SB'(sp_ff[2]);
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               m5_ff[j][k] <= MB'(MB'(ma_ff[j][k]) - MB'(mb_ff[j][k]));
            end
         end
         g5_ff <= g4_ff;
      end
   end

   // ---------------- stage 6: range checks, divider setup
   // A zero normal gives a zero denominator, so the sign check covers it.
   sti_pkg::div_type     d6_in;
   logic signed [SB-1:0] aden;

   always_comb begin
      aden        = -den_ff;
      d6_in.r     = RB'($unsigned(num_ff));
      d6_in.d     = RB'($unsigned(aden));
      d6_in.q     = '0;
      d6_in.eq    = (num_ff == aden);
      d6_in.miss  = !den_ff[SB-1] || num_ff[SB-1] || (aden < num_ff);
      d6_in.m     = m5_ff;
      d6_in.geo   = g5_ff;
   end

   // ---------------- divider: one quotient bit per stage
   logic             dv_v_ff [NS+1];
   sti_pkg::div_type dv_ff   [NS+1];
   sti_pkg::div_type dv_in   [NS];

   always_comb begin
      logic [RB-1:0] r2;
      for (int g = 0; g < NS; g++) begin
         dv_in[g] = dv_ff[g];
         r2       = {dv_ff[g].r[RB-2:0], 1'b0};
         if (r2 >= dv_ff[g].d) begin
            dv_in[g].r = r2 - dv_ff[g].d;
            dv_in[g].q = {dv_ff[g].q[TB-2:0], 1'b1};
         end else begin
            dv_in[g].r = r2;
            dv_in[g].q = {dv_ff[g].q[TB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g <= NS; g++) begin
            dv_v_ff[g] <= 1'b0;
         end
      end else if (en) begin
         dv_v_ff[0] <= v5_ff;
         for (int g = 0; g < NS; g++) begin
            dv_v_ff[g+1] <= dv_v_ff[g];
         end
      end
      if (en) begin
         dv_ff[0] <= d6_in;
         for (int g = 0; g < NS; g++) begin
            dv_ff[g+1] <= dv_in[g];
         end
      end
   end

   // ---------------- point stage 1: dir * t
   sti_pkg::div_type     dl;
   logic [TB:0]          tq;
   logic                 p1_v_ff;
   logic signed [QP-1:0] prod_ff [3];
   sti_pkg::geo_type     gp1_ff;
   logic [2:0][2:0][MB-1:0] mp1_ff;
   logic                 mp1_miss_ff;

   assign dl = dv_ff[NS];
   assign tq = dl.eq ? {1'b1, {TB{1'b0}}} : {1'b0, dl.q};

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else if (en) begin
         p1_v_ff <= dv_v_ff[NS];
      end
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            prod_ff[k] <= $signed(dl.geo.dir[k]) * $signed({1'b0, tq});
         end
         gp1_ff      <= dl.geo;
         mp1_ff      <= dl.m;
         mp1_miss_ff <= dl.miss;
      end
   end

   // ---------------- point stage 2: start + floor(dir * t / 2^16)
   logic                 p2_v_ff;
   logic signed [TP-1:0] pt_ff [3];
   sti_pkg::geo_type     gp2_ff;
   logic [2:0][2:0][MB-1:0] mp2_ff;
   logic                 mp2_miss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_v_ff <= 1'b0;
      end else if (en) begin
         p2_v_ff <= p1_v_ff;
      end
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            pt_ff[k] <= TP'($signed(gp1_ff.s[k]) + TP'(prod_ff[k] >>> TB));
         end
         gp2_ff      <= gp1_ff;
         mp2_ff      <= mp1_ff;
         mp2_miss_ff <= mp1_miss_ff;
      end
   end

   // ---------------- edge stage 1: point minus edge start
   logic                 p3_v_ff;
   logic signed [VB-1:0] dv3_ff [3][3];
   logic signed [TP-1:0] pt3_ff [3];
   logic [2:0][2:0][MB-1:0] mp3_ff;
   logic                 mp3_miss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_v_ff <= 1'b0;
      end else if (en) begin
         p3_v_ff <= p2_v_ff;
      end
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            dv3_ff[0][k] <= VB'(pt_ff[k]) - VB'($signed(gp2_ff.a[k]));
            dv3_ff[1][k] <= VB'(pt_ff[k]) - VB'($signed(gp2_ff.b[k]));
            dv3_ff[2][k] <= VB'(pt_ff[k]) - VB'($signed(gp2_ff.c[k]));
         end
         pt3_ff      <= pt_ff;
         mp3_ff      <= mp2_ff;
         mp3_miss_ff <= mp2_miss_ff;
      end
   end

   // ---------------- edge stage 2: split partial products
   logic                 p4_v_ff;
   logic signed [sti_pkg::PL_BITS-1:0] pl_ff [3][3];
   logic signed [sti_pkg::PH_BITS-1:0] ph_ff [3][3];
   logic signed [TP-1:0] pt4_ff [3];
   logic                 p4_miss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_v_ff <= 1'b0;
      end else if (en) begin
         p4_v_ff <= p3_v_ff;
      end
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               pl_ff[j][k] <= dv3_ff[j][k] * $signed({1'b0, mp3_ff[j][k][LB-1:0]});
               ph_ff[j][k] <= dv3_ff[j][k] * $signed(mp3_ff[j][k][MB-1:LB]);
            end
         end
         pt4_ff     <= pt3_ff;
         p4_miss_ff <= mp3_miss_ff;
      end
   end

   // ---------------- edge stage 3: sums of the low and high halves
   logic                 p5_v_ff;
   logic signed [sti_pkg::SL_BITS-1:0] sl_ff [3];
   logic signed [sti_pkg::SH_BITS-1:0] sh_ff [3];
   logic signed [TP-1:0] pt5_ff [3];
   logic                 p5_miss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_v_ff <= 1'b0;
      end else if (en) begin
         p5_v_ff <= p4_v_ff;
      end
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            sl_ff[j] <= sti_pkg::SL_BITS'(pl_ff[j][0]) + sti_pkg::SL_BITS'(pl_ff[j][1])
                        + sti_pkg::SL_BITS'(pl_ff[j][2]);
            sh_ff[j] <= sti_pkg::SH_BITS'(ph_ff[j][0]) + sti_pkg::SH_BITS'(ph_ff[j][1])
                        + sti_pkg::SH_BITS'(ph_ff[j][2]);
         end
         pt5_ff     <= pt4_ff;
         p5_miss_ff <= p4_miss_ff;
      end
   end

   // ---------------- final stage: edge signs and output register
   sti_pkg::rsp_type              rsp_data_ff, rsp_data_in;
   logic signed [sti_pkg::TOT_BITS-1:0] tot [3];
   logic [2:0]                    edge_ok;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         tot[j]     = (sti_pkg::TOT_BITS'(sh_ff[j]) <<< LB) + sti_pkg::TOT_BITS'(sl_ff[j]);
         edge_ok[j] = !tot[j][sti_pkg::TOT_BITS-1];
      end
      rsp_data_in.hit = !p5_miss_ff && (&edge_ok);
      if (rsp_data_in.hit) begin
         rsp_data_in.point_x = pt5_ff[0][15:0];
         rsp_data_in.point_y = pt5_ff[1][15:0];
         rsp_data_in.point_z = pt5_ff[2][15:0];
      end else begin
         rsp_data_in.point_x = '0;
         rsp_data_in.point_y = '0;
         rsp_data_in.point_z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= p5_v_ff;
      end
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A miss always reports a zero point.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |->
         rsp_data.point_x == 0 && rsp_data.point_y == 0 && rsp_data.point_z == 0)
      else $error("miss with nonzero point");

   // The divider remainder stays below the divisor when the parameter is
   // strictly inside its range; t of exactly one keeps the remainder at the divisor.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      dv_v_ff[NS] && !dl.miss && !dl.eq |-> dl.r < dl.d)
      else $error("divider remainder out of range");

   // A stalled output holds every stage, so the stage before it keeps its word.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(p5_v_ff) && $stable(v1_ff))
      else $error("pipeline moved during stall");

endmodule
